/* sv/stbs_pkg.sv */
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 9;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;
   localparam logic [1:0] ST_CMP   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] position;
   } result_type;

endpackage

/* sv/sorted_table_binary_search_top.sv */
// Top level of the sorted table binary search block.
//
// req_ channel: one beat is either a load (operation 0), which writes
// item_value into table entry entry_index and gives no result, or a search
// (operation 1), which looks item_value up in entries 0 .. min(entry_count, TABLE_DEPTH)-1.
// Loads to an index at or above TABLE_DEPTH are dropped.
// rsp_ channel: one beat per search with found and position (0 if missed).
// csr_ channel: writes entry_count; csr_ready is always high. Write it only
// while no search is in flight.
// A search probes the table RAM (ST_PROBE read, then ST_CMP compare) up to
// log2(TABLE_DEPTH)+1 times, then holds its result in ST_DONE until handed
// on. One search runs at a time; req_stall is high while it
// does. The finished result moves into an output register, so the next item
// is taken while rsp_valid waits under rsp_stall; a second finished search
// holds until that register frees.
// Reset clears entry_count and all handshake state; table contents are
// undefined until loaded.
module sorted_table_binary_search_top #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [stbs_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic signed [stbs_pkg::VALUE_W-1:0]  req_item_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_found,
   output logic [stbs_pkg::INDEX_W-1:0]         rsp_position,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [stbs_pkg::COUNT_W-1:0]         csr_data
);
   import stbs_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   result_type                rsp_ff, rsp_in;
   logic                      req_fire;
   logic                      wr_en;
   logic                      busy;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic signed [VALUE_W-1:0] rd_data;
   logic                      done_valid;
   logic                      done_ready;
   result_type                result;

   assign req_stall = busy;
   assign req_fire  = req_valid && !busy;
   assign wr_en     = req_fire && (req_operation == OP_LOAD)
                      && (32'(req_entry_index) < 32'(TABLE_DEPTH));
   assign csr_ready = 1'b1;

   stbs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (req_item_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   stbs_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW),
      .CW          (CW)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (req_fire && (req_operation == OP_SEARCH)),
      .key        (req_item_value),
      .count      (count_ff),
      .busy       (busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .result     (result)
   );

   // output register
   assign done_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_ff.found;
   assign rsp_position = rsp_ff.position;

endmodule

/* sv/stbs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module stbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/stbs_engine.sv */
// Binary search sequencer: bounds, probe address, compare and result handoff.
module stbs_engine #(
   parameter int TABLE_DEPTH = 256,
   parameter int AW          = 8,
   parameter int CW          = 9
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [stbs_pkg::VALUE_W-1:0]  key,
   input  logic [stbs_pkg::COUNT_W-1:0]         count,
   output logic                                 busy,
   output logic                                 rd_en,
   output logic [AW-1:0]                        rd_addr,
   input  logic signed [stbs_pkg::VALUE_W-1:0]  rd_data,
   output logic                                 done_valid,
   input  logic                                 done_ready,
   output stbs_pkg::result_type                 result
);
   import stbs_pkg::*;

   logic [1:0]                 state_ff, state_in;
   logic [CW-1:0]              lo_ff, lo_in;
   logic [CW-1:0]              hi_ff, hi_in;
   logic signed [VALUE_W-1:0]  key_ff, key_in;
   result_type                 res_ff, res_in;
   logic [CW:0]                mid_sum;
   logic [CW-1:0]              mid;
   logic [CW-1:0]              n_sat;
   logic [CW-1:0]              lo_nx, hi_nx;

   assign n_sat   = (32'(count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - (CW+1)'(1);
   assign mid     = mid_sum[CW:1];

   assign busy       = (state_ff != ST_IDLE);
   assign rd_en      = (state_ff == ST_PROBE);
   assign rd_addr    = mid[AW-1:0];
   assign done_valid = (state_ff == ST_DONE);
   assign result     = res_ff;

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      key_in   = key_ff;
      res_in   = res_ff;
      lo_nx    = lo_ff;
      hi_nx    = hi_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               lo_in           = '0;
               hi_in           = n_sat;
               key_in          = key;
               res_in.found    = 1'b0;
               res_in.position = '0;
               state_in        = (n_sat != '0) ? ST_PROBE : ST_DONE;
            end
         end
         ST_PROBE: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (key_ff == rd_data) begin
               res_in.found    = 1'b1;
               res_in.position = INDEX_W'(mid);
               state_in        = ST_DONE;
            end else begin
               if (key_ff < rd_data) begin
                  hi_nx = mid;
               end else begin
                  lo_nx = mid + CW'(1);
               end
               lo_in    = lo_nx;
               hi_in    = hi_nx;
               state_in = (lo_nx < hi_nx) ? ST_PROBE : ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      key_ff <= key_in;
      res_ff <= res_in;
   end

endmodule

/* dv/stbs_lookup_check.sv */
// Search result predictor and comparator for the sorted table binary search block.
`timescale 1ns / 1ps
module stbs_lookup_check #(
   parameter int TABLE_SIZE = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_operation,
   input  logic [stbs_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic signed [stbs_pkg::VALUE_W-1:0] req_item_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_found,
   input  logic [stbs_pkg::INDEX_W-1:0]        rsp_position,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [stbs_pkg::COUNT_W-1:0]        csr_data,
   output int                                  error_count,
   output int                                  pending_count,
   output int                                  hit_count
);
   import stbs_pkg::*;

   logic signed [VALUE_W-1:0] table_copy [0:TABLE_SIZE-1];
   logic [COUNT_W-1:0]        count_copy;
   result_type                answers [$];
   result_type                want;
   int                        errors;
   int                        hits;

   initial begin
      error_count   = 0;
      pending_count = 0;
      hit_count     = 0;
      errors        = 0;
      hits          = 0;
      count_copy    = '0;
   end

   function automatic result_type search_table(input logic signed [VALUE_W-1:0] key);
      int         lo;
      int         hi;
      int         mid;
      result_type r;
      r  = '0;
      lo = 0;
      hi = (int'(count_copy) > TABLE_SIZE) ? TABLE_SIZE : int'(count_copy);
      while (lo < hi && !r.found) begin
         mid = (lo + hi - 1) / 2;
         if (key < table_copy[mid]) begin
            hi = mid;
         end else if (key > table_copy[mid]) begin
            lo = mid + 1;
         end else begin
            r.found    = 1'b1;
            r.position = mid[INDEX_W-1:0];
         end
      end
      return r;
   endfunction

   task automatic report_miss(input bit had_answer, input result_type exp_r);
      errors++;
      if (errors <= 10) begin
         if (had_answer) begin
            $display("%0t mismatch: expected found=%0d position=%0d, got found=%0d position=%0d",
                     $time, exp_r.found, exp_r.position, rsp_found, rsp_position);
         end else begin
            $display("%0t result beat with no search pending: found=%0d position=%0d",
                     $time, rsp_found, rsp_position);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         count_copy = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            count_copy = csr_data;
         end
         if (req_valid && !req_stall) begin
            if (req_operation == OP_LOAD) begin
               if (int'(req_entry_index) < TABLE_SIZE) begin
                  table_copy[req_entry_index] = req_item_value;
               end
            end else begin
               want = search_table(req_item_value);
               if (want.found) begin
                  hits++;
               end
               answers.push_back(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (answers.size() == 0) begin
               report_miss(1'b0, '0);
            end else begin
               want = answers.pop_front();
               if (want.found !== rsp_found || want.position !== rsp_position) begin
                  report_miss(1'b1, want);
               end
            end
         end
      end
      error_count   <= errors;
      pending_count <= answers.size();
      hit_count     <= hits;
   end

endmodule

/* dv/sorted_table_binary_search_top_test.sv */
// Testbench top: stimulus, handshake idling, watchdog and verdict for the search block.
`timescale 1ns / 1ps
module sorted_table_binary_search_top_test;
   import stbs_pkg::*;

   localparam int TABLE_SIZE     = 256;
   localparam int IDLE_WAIT      = 24;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic signed [VALUE_W-1:0] MIN_VALUE = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;
   localparam longint                    VALUE_LO  = -64'sd2147483648;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic                      req_stall;
   logic                      req_operation   = OP_LOAD;
   logic [INDEX_W-1:0]        req_entry_index = '0;
   logic signed [VALUE_W-1:0] req_item_value  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall       = 1'b0;
   logic                      rsp_found;
   logic [INDEX_W-1:0]        rsp_position;
   logic                      csr_valid       = 1'b0;
   logic                      csr_ready;
   logic [COUNT_W-1:0]        csr_data        = '0;

   int error_count;
   int pending_count;
   int hit_count;

   logic signed [VALUE_W-1:0] fill_values [0:TABLE_SIZE-1];
   int burst_left    = 0;
   int stall_left    = 0;
   int quiet_cycles  = 0;
   int loads_sent    = 0;
   int searches_sent = 0;
   int count_writes  = 0;

   sorted_table_binary_search_top #(.TABLE_DEPTH(TABLE_SIZE)) i_dut (.*);

   stbs_lookup_check #(.TABLE_SIZE(TABLE_SIZE)) i_lookup_check (.*);

   always #1 clock = ~clock;

   // receiver: runs of random stall or no stall, sometimes a long calm run
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         if ($urandom_range(0, 9) == 0) begin
            rsp_stall  <= 1'b0;
            stall_left <= 60;
         end else begin
            rsp_stall  <= ($urandom_range(0, 2) == 0);
            stall_left <= $urandom_range(1, 12);
         end
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d searches pending",
                  quiet_cycles, pending_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_beat(input logic op, input logic [INDEX_W-1:0] idx,
                            input logic signed [VALUE_W-1:0] val);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_entry_index <= idx;
      req_item_value  <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_LOAD) begin
         loads_sent++;
      end else begin
         searches_sent++;
      end
   endtask

   // hold off until every search has answered and the block has gone quiet
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_count(input int n);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= COUNT_W'(n);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      count_writes++;
   endtask

   // ascending contents; narrow spans give duplicates
   task automatic make_table(input int m, input int mode);
      longint span;
      longint room;
      longint v;
      case (mode)
         0:       span = 3;
         1:       span = 2000;
         default: span = 64'h1_0000_0000 / (m + 1);
      endcase
      room = 64'hFFFF_FFFF - longint'(m) * (span - 1);
      v    = VALUE_LO + (longint'($urandom) % (room + 1));
      for (int i = 0; i < m; i++) begin
         fill_values[i] = v[VALUE_W-1:0];
         v += longint'($urandom) % span;
      end
      if (m > 0 && mode == 2 && ($urandom_range(0, 2) == 0 || m == TABLE_SIZE)) begin
         fill_values[0]   = MIN_VALUE;
         fill_values[m-1] = MAX_VALUE;
      end
   endtask

   task automatic load_table(input int m);
      for (int i = 0; i < m; i++) begin
         send_beat(OP_LOAD, INDEX_W'(i), fill_values[i]);
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_key(input int m);
      int sel;
      int i;
      sel = $urandom_range(0, 19);
      i   = (m > 0) ? $urandom_range(0, m - 1) : 0;
      if (m > 0 && sel < 10) begin
         return fill_values[i];
      end else if (m > 0 && sel < 15) begin
         return ($urandom_range(0, 1) == 0) ? fill_values[i] + 32'sd1 : fill_values[i] - 32'sd1;
      end else if (sel < 17) begin
         case ($urandom_range(0, 3))
            0:       return MIN_VALUE;
            1:       return MAX_VALUE;
            2:       return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   // m is the number of entries the search sees; noisy loads may unsort the table
   task automatic run_searches(input int m, input int k, input bit noisy);
      int idx;
      for (int j = 0; j < k; j++) begin
         if ($urandom_range(0, 9) == 0) begin
            idx = $urandom_range(0, TABLE_SIZE - 1);
            send_beat(OP_LOAD, INDEX_W'(idx), noisy ? $urandom : fill_values[idx]);
         end
         if ($urandom_range(0, 24) == 0) begin
            drain();
         end
         send_beat(OP_SEARCH, INDEX_W'($urandom_range(0, 255)), pick_key(m));
      end
   endtask

   int n;
   int sel;
   int big_counts [7];

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty table after reset
      send_beat(OP_SEARCH, 8'h00, 32'sd0);
      send_beat(OP_SEARCH, 8'hFF, MIN_VALUE);

      send_beat(OP_LOAD, 8'd0, MIN_VALUE);
      send_beat(OP_LOAD, 8'd1, -32'sd1);
      send_beat(OP_LOAD, 8'd2, 32'sd0);
      send_beat(OP_LOAD, 8'd3, 32'sd5);
      send_beat(OP_LOAD, 8'd4, MAX_VALUE);
      send_beat(OP_LOAD, 8'hFF, 32'sd1234);
      write_count(5);
      send_beat(OP_SEARCH, 8'h00, MIN_VALUE);
      send_beat(OP_SEARCH, 8'hFF, -32'sd1);
      send_beat(OP_SEARCH, 8'h55, 32'sd0);
      send_beat(OP_SEARCH, 8'hAA, 32'sd5);
      send_beat(OP_SEARCH, 8'h01, MAX_VALUE);
      send_beat(OP_SEARCH, 8'h02, 32'sd3);
      send_beat(OP_SEARCH, 8'h03, 32'sd6);
      send_beat(OP_SEARCH, 8'h04, MIN_VALUE + 32'sd1);

      // unsorted: entry 1 out of order, skipped by the probes
      send_beat(OP_LOAD, 8'd1, 32'sd100);
      send_beat(OP_SEARCH, 8'h00, 32'sd100);
      send_beat(OP_SEARCH, 8'h00, 32'sd0);

      write_count(1);
      send_beat(OP_SEARCH, 8'h00, MIN_VALUE);
      send_beat(OP_SEARCH, 8'h00, 32'sd7);

      // small tables, fresh contents each time
      for (int p = 0; p < 13; p++) begin
         sel = $urandom_range(0, 7);
         n   = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(17, 40) : $urandom_range(1, 16);
         make_table(n, $urandom_range(0, 2));
         load_table(n);
         write_count(n);
         run_searches(n, $urandom_range(8, 14), 1'b1);
      end

      // one full sorted table, then counts up to and beyond the depth
      make_table(TABLE_SIZE, 2);
      load_table(TABLE_SIZE);
      big_counts = '{256, 511, 300, 255, 128, 2, 0};
      big_counts[6] = $urandom_range(257, 510);
      foreach (big_counts[c]) begin
         write_count(big_counts[c]);
         n = (big_counts[c] > TABLE_SIZE) ? TABLE_SIZE : big_counts[c];
         run_searches(n, $urandom_range(10, 14), 1'b0);
      end

      drain();
      $display("%0d loads, %0d searches (%0d hits), %0d entry_count writes",
               loads_sent, searches_sent, hit_count, count_writes);
      $display("tables from empty to %0d entries, saturated counts, duplicates, unsorted entries",
               TABLE_SIZE);
      if (error_count + pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
